// ===== rtl/assert_macros.svh =====
// Assertion macros of the key/value pair sorter modules.
// Depends on nothing; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define KVPS_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("kvps assertion failed");

// Checks that a condition never holds outside reset.
`define KVPS_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("kvps forbidden condition seen");

`endif

// ===== rtl/kvps_pkg.sv =====
// Package of the key/value pair sorter: widths, defaults, state and control types.
// Depends on nothing; used by the controller, datapath and top level.
`timescale 1ns / 1ps

package kvps_pkg;

  localparam int DATA_W        = 32;
  localparam int PAIR_W        = 2 * DATA_W;
  localparam int MAX_PAIRS_DEF = 64;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_INS_CHECK,
    ST_INS_CMP,
    ST_DRAIN
  } kvps_state_t;

  typedef struct packed {
    logic load;
    logic drop;
    logic ins_read;
    logic ins_shift;
    logic ins_place;
    logic drain_issue;
  } kvps_cmd_t;

  typedef struct packed {
    logic room;
    logic last_item;
    logic j_zero;
    logic greater;
    logic drain_last;
  } kvps_stat_t;

endpackage

// ===== rtl/kvps_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
`timescale 1ns / 1ps

module kvps_ram #(
  parameter int Width = 64,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(Depth)-1:0] wr_addr,
  input  logic [Width-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(Depth)-1:0] rd_addr,
  output logic [Width-1:0]         rd_data
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/kvps_ctrl.sv =====
// Controller of the key/value pair sorter: sequences insertion and drain.
// Depends on kvps_pkg.
`timescale 1ns / 1ps

module kvps_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               in_final_item,
  input  kvps_pkg::kvps_stat_t stat,
  output kvps_pkg::kvps_cmd_t  cmd,
  output logic               busy
);

  kvps_pkg::kvps_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= kvps_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      kvps_pkg::ST_IDLE: begin
        if (start) begin
          if (stat.room) begin
            state_nxt = kvps_pkg::ST_INS_CHECK;
          end else if (in_final_item) begin
            state_nxt = kvps_pkg::ST_DRAIN;
          end
        end
      end
      kvps_pkg::ST_INS_CHECK: begin
        if (!stat.j_zero) begin
          state_nxt = kvps_pkg::ST_INS_CMP;
        end else if (stat.last_item) begin
          state_nxt = kvps_pkg::ST_DRAIN;
        end else begin
          state_nxt = kvps_pkg::ST_IDLE;
        end
      end
      kvps_pkg::ST_INS_CMP: begin
        if (stat.greater) begin
          state_nxt = kvps_pkg::ST_INS_CHECK;
        end else if (stat.last_item) begin
          state_nxt = kvps_pkg::ST_DRAIN;
        end else begin
          state_nxt = kvps_pkg::ST_IDLE;
        end
      end
      kvps_pkg::ST_DRAIN: begin
        if (stat.drain_last) begin
          state_nxt = kvps_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = kvps_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    case (state_r)
      kvps_pkg::ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
        cmd.drop = start && !stat.room;
      end
      kvps_pkg::ST_INS_CHECK: begin
        cmd.ins_place = stat.j_zero;
        cmd.ins_read  = !stat.j_zero;
      end
      kvps_pkg::ST_INS_CMP: begin
        cmd.ins_shift = stat.greater;
        cmd.ins_place = !stat.greater;
      end
      kvps_pkg::ST_DRAIN: begin
        cmd.drain_issue = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

endmodule

// ===== rtl/kvps_dp.sv =====
// Datapath of the key/value pair sorter: pair registers, counters, compare and store.
// Depends on kvps_pkg, kvps_ram and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module kvps_dp #(
  parameter int MaxPairs = kvps_pkg::MAX_PAIRS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic signed [kvps_pkg::DATA_W-1:0] in_key,
  input  logic signed [kvps_pkg::DATA_W-1:0] in_payload,
  input  logic                              in_final_item,
  input  kvps_pkg::kvps_cmd_t                cmd,
  output kvps_pkg::kvps_stat_t               stat,
  output logic                              out_strobe,
  output logic signed [kvps_pkg::DATA_W-1:0] out_sorted_key,
  output logic signed [kvps_pkg::DATA_W-1:0] out_sorted_payload,
  output logic                              out_end_of_run,
  output logic                              out_overflowed
);

  localparam int AddrW = $clog2(MaxPairs);
  localparam int CntW  = $clog2(MaxPairs + 1);

  logic [kvps_pkg::PAIR_W-1:0] pair_r;
  logic                        final_r;
  logic [CntW-1:0]             count_r;
  logic                        drop_r;
  logic [AddrW-1:0]            j_r;
  logic [AddrW-1:0]            i_r;
  logic                        out_valid_r;
  logic                        out_last_r;
  logic                        out_ovf_r;

  logic                        wr_en;
  logic [AddrW-1:0]            rd_addr;
  logic [kvps_pkg::PAIR_W-1:0] wr_data;
  logic [kvps_pkg::PAIR_W-1:0] rd_data;
  logic signed [kvps_pkg::DATA_W-1:0] rd_key, rd_pay, cur_key, cur_pay;

  assign rd_key  = $signed(rd_data[kvps_pkg::PAIR_W-1:kvps_pkg::DATA_W]);
  assign rd_pay  = $signed(rd_data[kvps_pkg::DATA_W-1:0]);
  assign cur_key = $signed(pair_r[kvps_pkg::PAIR_W-1:kvps_pkg::DATA_W]);
  assign cur_pay = $signed(pair_r[kvps_pkg::DATA_W-1:0]);

  assign stat.room       = count_r < CntW'(MaxPairs);
  assign stat.last_item  = final_r;
  assign stat.j_zero     = j_r == '0;
  assign stat.greater    = (rd_key > cur_key) || ((rd_key == cur_key) && (rd_pay > cur_pay));
  assign stat.drain_last = (CntW'(i_r) + CntW'(1)) == count_r;

  assign wr_en   = cmd.ins_shift || cmd.ins_place;
  assign wr_data = cmd.ins_place ? pair_r : rd_data;
  assign rd_addr = cmd.ins_read ? (j_r - AddrW'(1)) : i_r;

  kvps_ram #(
    .Width (kvps_pkg::PAIR_W),
    .Depth (MaxPairs)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (j_r),
    .wr_data (wr_data),
    .rd_en   (cmd.ins_read || cmd.drain_issue),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pair_r  <= {in_key, in_payload};
      final_r <= in_final_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      drop_r      <= 1'b0;
      j_r         <= '0;
      i_r         <= '0;
      out_valid_r <= 1'b0;
      out_last_r  <= 1'b0;
      out_ovf_r   <= 1'b0;
    end else begin
      out_valid_r <= cmd.drain_issue;
      out_last_r  <= stat.drain_last;
      out_ovf_r   <= drop_r;
      if (cmd.load) begin
        j_r <= count_r[AddrW-1:0];
        i_r <= '0;
      end
      if (cmd.drop) begin
        drop_r <= 1'b1;
      end
      if (cmd.ins_shift) begin
        j_r <= j_r - AddrW'(1);
      end
      if (cmd.ins_place) begin
        count_r <= count_r + CntW'(1);
      end
      if (cmd.drain_issue) begin
        i_r <= i_r + AddrW'(1);
        if (stat.drain_last) begin
          count_r <= '0;
          drop_r  <= 1'b0;
        end
      end
    end
  end

  assign out_strobe         = out_valid_r;
  assign out_sorted_key     = rd_key;
  assign out_sorted_payload = rd_pay;
  assign out_end_of_run     = out_last_r;
  assign out_overflowed     = out_ovf_r;

  `KVPS_NEVER(a_count_bound, clk, rst_n, count_r > CntW'(MaxPairs))
  `KVPS_ASSERT(a_drop_when_full, clk, rst_n, cmd.drop |-> count_r == CntW'(MaxPairs))
  `KVPS_ASSERT(a_shift_has_room, clk, rst_n, cmd.ins_shift |-> j_r != '0)
  `KVPS_ASSERT(a_last_ends_run, clk, rst_n, (out_valid_r && out_last_r) |=> !out_valid_r)

endmodule

// ===== rtl/key_value_pair_sorter_top.sv =====
// Top level of the key/value pair sorter: controller and datapath joined.
// Depends on kvps_pkg, kvps_ctrl and kvps_dp.
`timescale 1ns / 1ps

// Pairs are taken while busy is low, kept in key order by insertion into one
// RAM, and streamed out after the word marked final. A stored pair keeps busy
// high while each stored pair that ranks above it moves up: the registered
// read of that neighbor in ST_INS_CHECK, its compare and write back in
// ST_INS_CMP. The pair is then written in ST_INS_CHECK, or in ST_INS_CMP
// once a stored pair ranks below it. A pair that arrives with the store full
// is dropped, and unless it is final it leaves busy low. After the final
// word the n stored pairs are drained from the RAM one per cycle, busy stays
// high through the drain, and the words appear on consecutive cycles from
// the cycle after the drain starts. The receiver cannot stall: each word is
// shown for exactly one cycle with out_strobe high.
module key_value_pair_sorter_top #(
  parameter int MAX_PAIRS = kvps_pkg::MAX_PAIRS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [kvps_pkg::DATA_W-1:0] in_key,
  input  logic signed [kvps_pkg::DATA_W-1:0] in_payload,
  input  logic                              in_final_item,
  output logic                              out_strobe,
  output logic signed [kvps_pkg::DATA_W-1:0] out_sorted_key,
  output logic signed [kvps_pkg::DATA_W-1:0] out_sorted_payload,
  output logic                              out_end_of_run,
  output logic                              out_overflowed
);

  kvps_pkg::kvps_cmd_t  cmd;
  kvps_pkg::kvps_stat_t stat;

  kvps_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .in_final_item (in_final_item),
    .stat          (stat),
    .cmd           (cmd),
    .busy          (busy)
  );

  kvps_dp #(
    .MaxPairs (MAX_PAIRS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_key             (in_key),
    .in_payload         (in_payload),
    .in_final_item      (in_final_item),
    .cmd                (cmd),
    .stat               (stat),
    .out_strobe         (out_strobe),
    .out_sorted_key     (out_sorted_key),
    .out_sorted_payload (out_sorted_payload),
    .out_end_of_run     (out_end_of_run),
    .out_overflowed     (out_overflowed)
  );

endmodule

// ===== tb/sv/key_value_pair_sorter_top_tb.sv =====
// Testbench of key_value_pair_sorter_top: directed and random batches of pairs,
// with sorted words checked against a behavioral sort of each accepted batch.
// Depends on kvps_pkg and the sorter RTL.
`timescale 1ns / 1ps

module key_value_pair_sorter_top_tb;

  localparam int DATA_W       = kvps_pkg::DATA_W;
  localparam int CAPACITY     = kvps_pkg::MAX_PAIRS_DEF;
  localparam int RANDOM_PAIRS = 210;
  localparam int QUIET_TAIL   = 30;
  localparam int STALL_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 20;

  localparam logic signed [DATA_W-1:0] WORD_MIN = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic signed [DATA_W-1:0] WORD_MAX = {1'b0, {(DATA_W-1){1'b1}}};

  typedef struct {
    logic signed [DATA_W-1:0] key;
    logic signed [DATA_W-1:0] payload;
    logic                     is_last;
  } pair_word_t;

  typedef struct {
    logic signed [DATA_W-1:0] key;
    logic signed [DATA_W-1:0] payload;
    logic                     end_of_run;
    logic                     overflowed;
  } sorted_word_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     start = 1'b0;
  logic                     busy;
  logic signed [DATA_W-1:0] in_key = '0;
  logic signed [DATA_W-1:0] in_payload = '0;
  logic                     in_final_item = 1'b0;
  logic                     out_strobe;
  logic signed [DATA_W-1:0] out_sorted_key;
  logic signed [DATA_W-1:0] out_sorted_payload;
  logic                     out_end_of_run;
  logic                     out_overflowed;

  pair_word_t   pairs_to_send[$];
  sorted_word_t sorted_due[$];

  logic signed [DATA_W-1:0] held_keys [CAPACITY];
  logic signed [DATA_W-1:0] held_payloads [CAPACITY];
  int   held_count = 0;
  logic held_dropped = 1'b0;

  int mismatches = 0;
  int pairs_accepted = 0;
  int words_checked = 0;
  int batches_sorted = 0;
  int batches_overflowed = 0;
  int gap_left = 0;
  int stall_cycles = 0;
  bit gaps_enabled = 1'b1;

  key_value_pair_sorter_top #(
    .MAX_PAIRS(CAPACITY)
  ) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_key            (in_key),
    .in_payload        (in_payload),
    .in_final_item     (in_final_item),
    .out_strobe        (out_strobe),
    .out_sorted_key    (out_sorted_key),
    .out_sorted_payload(out_sorted_payload),
    .out_end_of_run    (out_end_of_run),
    .out_overflowed    (out_overflowed)
  );

  always #5 clk = ~clk;

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("MISMATCH at %0t ns: %s", $time, what);
  endtask

  function automatic bit ranks_above(input logic signed [DATA_W-1:0] a_key,
                                     input logic signed [DATA_W-1:0] a_pay,
                                     input logic signed [DATA_W-1:0] b_key,
                                     input logic signed [DATA_W-1:0] b_pay);
    return (a_key > b_key) || (a_key == b_key && a_pay > b_pay);
  endfunction

  // Stores or drops one accepted pair; a final word sorts the batch and queues its words.
  task automatic absorb_pair(input logic signed [DATA_W-1:0] key,
                             input logic signed [DATA_W-1:0] payload,
                             input logic is_last);
    logic signed [DATA_W-1:0] keys [CAPACITY];
    logic signed [DATA_W-1:0] pays [CAPACITY];
    logic signed [DATA_W-1:0] k;
    logic signed [DATA_W-1:0] p;
    int j;
    sorted_word_t w;
    if (held_count < CAPACITY) begin
      held_keys[held_count] = key;
      held_payloads[held_count] = payload;
      held_count++;
    end else begin
      held_dropped = 1'b1;
    end
    if (!is_last) return;
    for (int i = 0; i < held_count; i++) begin
      keys[i] = held_keys[i];
      pays[i] = held_payloads[i];
    end
    for (int i = 1; i < held_count; i++) begin
      k = keys[i];
      p = pays[i];
      j = i;
      while (j > 0 && ranks_above(keys[j-1], pays[j-1], k, p)) begin
        keys[j] = keys[j-1];
        pays[j] = pays[j-1];
        j--;
      end
      keys[j] = k;
      pays[j] = p;
    end
    for (int i = 0; i < held_count; i++) begin
      w.key = keys[i];
      w.payload = pays[i];
      w.end_of_run = (i == held_count - 1);
      w.overflowed = held_dropped;
      sorted_due.push_back(w);
    end
    batches_sorted++;
    if (held_dropped) batches_overflowed++;
    held_count = 0;
    held_dropped = 1'b0;
  endtask

  function automatic logic signed [DATA_W-1:0] rand_word();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0: return WORD_MIN;
          1: return WORD_MAX;
          2: return '0;
          default: return '1;
        endcase
      end
      1, 2, 3: return $signed($urandom_range(0, 8)) - 4;
      default: return $urandom;
    endcase
  endfunction

  task automatic queue_pair(input logic signed [DATA_W-1:0] key,
                            input logic signed [DATA_W-1:0] payload,
                            input logic is_last);
    pair_word_t w;
    w.key = key;
    w.payload = payload;
    w.is_last = is_last;
    pairs_to_send.push_back(w);
  endtask

  task automatic queue_batch(input int size);
    for (int i = 0; i < size; i++) begin
      queue_pair(rand_word(), rand_word(), i == size - 1);
    end
  endtask

  always @(posedge clk) begin : driver
    logic taken;
    taken = start && !busy;
    if (!rst_n) begin
      start <= 1'b0;
      gap_left = 0;
    end else begin
      if (taken) begin
        absorb_pair(in_key, in_payload, in_final_item);
        void'(pairs_to_send.pop_front());
        pairs_accepted++;
        if ($urandom_range(0, 24) == 0) gaps_enabled = !gaps_enabled;
      end
      if (!(start && !taken)) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (pairs_to_send.size() == 0) begin
          start <= 1'b0;
        end else if (gaps_enabled && pairs_to_send.size() > QUIET_TAIL &&
                     $urandom_range(0, 3) == 0) begin
          gap_left = $urandom_range(0, 4);
          start <= 1'b0;
        end else begin
          start <= 1'b1;
          in_key <= pairs_to_send[0].key;
          in_payload <= pairs_to_send[0].payload;
          in_final_item <= pairs_to_send[0].is_last;
        end
      end
    end
  end

  always @(posedge clk) begin : monitor
    sorted_word_t due;
    if (rst_n && out_strobe) begin
      if (sorted_due.size() == 0) begin
        report_mismatch($sformatf("unexpected word key=%0d payload=%0d",
                                  out_sorted_key, out_sorted_payload));
      end else begin
        due = sorted_due.pop_front();
        words_checked++;
        if (out_sorted_key !== due.key)
          report_mismatch($sformatf("sorted_key %0d, expected %0d",
                                    out_sorted_key, due.key));
        if (out_sorted_payload !== due.payload)
          report_mismatch($sformatf("sorted_payload %0d, expected %0d",
                                    out_sorted_payload, due.payload));
        if (out_end_of_run !== due.end_of_run)
          report_mismatch($sformatf("end_of_run %b, expected %b",
                                    out_end_of_run, due.end_of_run));
        if (out_overflowed !== due.overflowed)
          report_mismatch($sformatf("overflowed %b, expected %b",
                                    out_overflowed, due.overflowed));
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (!rst_n || (start && !busy) || out_strobe) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Timeout: no word moved for %0d cycles.", STALL_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin : stimulus
    int random_pairs;
    int size;
    bit full_done;
    bit overflow_done;
    random_pairs = 0;
    full_done = 1'b0;
    overflow_done = 1'b0;

    queue_pair(WORD_MIN, WORD_MAX, 1'b1);
    queue_pair(WORD_MAX, WORD_MIN, 1'b1);
    queue_pair(WORD_MAX, '0, 1'b0);
    queue_pair(WORD_MIN, 5, 1'b0);
    queue_pair('0, '1, 1'b0);
    queue_pair('1, '0, 1'b0);
    queue_pair('0, WORD_MIN, 1'b0);
    queue_pair('0, WORD_MAX, 1'b0);
    queue_pair('1, '0, 1'b0);
    queue_pair(WORD_MIN, WORD_MIN, 1'b1);
    for (int i = 5; i >= 1; i--) queue_pair(i, -i, i == 1);
    for (int i = 0; i < 4; i++) queue_pair(7, 3 - i, i == 3);

    while (random_pairs < RANDOM_PAIRS) begin
      if (random_pairs >= 40 && !full_done) begin
        size = CAPACITY;
        full_done = 1'b1;
      end else if (random_pairs >= 140 && !overflow_done) begin
        size = CAPACITY + 2;
        overflow_done = 1'b1;
      end else begin
        size = $urandom_range(1, 10);
      end
      queue_batch(size);
      random_pairs += size;
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    while (pairs_to_send.size() > 0 || sorted_due.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sorted %0d batches (%0d of them over capacity) from %0d pairs.",
             batches_sorted, batches_overflowed, pairs_accepted);
    $display("Checked %0d sorted words, %0d mismatches.", words_checked, mismatches);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/kvps_pkg.sv
rtl/kvps_ram.sv
rtl/kvps_ctrl.sv
rtl/kvps_dp.sv
rtl/key_value_pair_sorter_top.sv
tb/sv/key_value_pair_sorter_top_tb.sv
